// ----- src/sevseg_pkg.sv -----
// Shared constants, types and helpers for the seven-segment display multiplexer.
// No dependencies.
package sevseg_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int DIGIT_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam int SEG_W      = 8;
  localparam int LEVEL_W    = 16;
  localparam int ELAPSED_W  = 17;
  localparam int COUNT_W    = 4;
  localparam int PHASE_W    = 2;
  localparam int DRIVE_W    = 4;
  localparam int IDX_W      = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam logic [PHASE_W-1:0] PH_ALL_OFF = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SETUP   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ON      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COMMON_ANODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_MODE     = 2'd2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic               common_anode;
    logic [LEVEL_W-1:0] off_time;
  } cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] digit_drive;
    logic [SEG_W-1:0]   segment_drive;
    logic [PHASE_W-1:0] phase_code;
  } result_t;

  // hold time in microseconds by lit segment count
  function automatic logic [ELAPSED_W-1:0] hold_time(input logic [COUNT_W-1:0] cnt);
    logic [ELAPSED_W-1:0] t;
    case (cnt)
      4'd1:    t = 17'd20;
      4'd2:    t = 17'd200;
      4'd3:    t = 17'd300;
      4'd4:    t = 17'd400;
      default: t = 17'd500;
    endcase
    return t;
  endfunction

  function automatic logic [COUNT_W-1:0] count_ones(input logic [SEG_W-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SEG_W; i++) begin
      n = n + COUNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ----- src/sevseg_if.sv -----
// Valid/ready channel interfaces for the display multiplexer.
// Depends on sevseg_pkg.
interface sevseg_in_if;
  import sevseg_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IDX_W-1:0] digit_index;
  logic [SEG_W-1:0] segment_pattern;

  modport source (output valid, cmd, digit_index, segment_pattern, input ready);
  modport sink   (input valid, cmd, digit_index, segment_pattern, output ready);
endinterface

interface sevseg_out_if;
  import sevseg_pkg::*;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] digit_drive;
  logic [SEG_W-1:0]   segment_drive;
  logic [PHASE_W-1:0] phase_code;

  modport source (output valid, digit_drive, segment_drive, phase_code, input ready);
  modport sink   (input valid, digit_drive, segment_drive, phase_code, output ready);
endinterface

// ----- src/sevseg_cfg.sv -----
// Configuration registers and registered off-time computation.
// Depends on sevseg_pkg.
module sevseg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sevseg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sevseg_pkg::LEVEL_W-1:0]   cfg_wdata,
  output sevseg_pkg::cfg_t              cfg
);
  import sevseg_pkg::*;

  logic               common_anode_r;
  logic [LEVEL_W-1:0] level_r;
  logic               exp_mode_r;
  logic [LEVEL_W-1:0] off_time_r;
  logic [LEVEL_W-1:0] off_time_nxt;
  logic [2*LEVEL_W-1:0] square;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_anode_r <= 1'b0;
      level_r        <= '0;
      exp_mode_r     <= 1'b0;
      off_time_r     <= '0;
    end else begin
      off_time_r <= off_time_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COMMON_ANODE: common_anode_r <= cfg_wdata[0];
          REG_BRIGHTNESS:   level_r        <= cfg_wdata;
          REG_EXP_MODE:     exp_mode_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign square       = level_r * level_r;
  assign off_time_nxt = exp_mode_r ? square[LEVEL_W-1:0] : level_r;

  assign cfg.common_anode = common_anode_r;
  assign cfg.off_time     = off_time_r;

endmodule

// ----- src/sevseg_core.sv -----
// Multiplexing state machine, pattern store and pin polarity.
// Depends on sevseg_pkg.
module sevseg_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         cmd,
  input  logic [sevseg_pkg::IDX_W-1:0] digit_index,
  input  logic [sevseg_pkg::SEG_W-1:0] segment_pattern,
  input  sevseg_pkg::cfg_t             cfg,
  output sevseg_pkg::result_t          result
);
  import sevseg_pkg::*;

  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [DIGIT_W-1:0]    digit_r, digit_nxt;
  logic [COUNT_W-1:0]    lit_r, lit_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [NUM_DIGITS-1:0] dlatch_r, dlatch_nxt;
  logic [SEG_W-1:0]      slatch_r, slatch_nxt;
  logic [SEG_W-1:0]      pattern_r [NUM_DIGITS];
  logic [ELAPSED_W-1:0]  el_inc;
  logic [SEG_W-1:0]      cur_pat;
  logic [DRIVE_W-1:0]    dl4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ALL_OFF;
      digit_r   <= '0;
      lit_r     <= '0;
      elapsed_r <= '0;
      dlatch_r  <= '0;
      slatch_r  <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        pattern_r[i] <= '0;
      end
    end else if (step) begin
      phase_r   <= phase_nxt;
      digit_r   <= digit_nxt;
      lit_r     <= lit_nxt;
      elapsed_r <= elapsed_nxt;
      dlatch_r  <= dlatch_nxt;
      slatch_r  <= slatch_nxt;
      if (cmd == CMD_WRITE) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (int'(digit_index) == i) begin
            pattern_r[i] <= segment_pattern;
          end
        end
      end
    end
  end

  assign el_inc  = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign cur_pat = pattern_r[digit_r];

  always_comb begin
    phase_nxt   = phase_r;
    digit_nxt   = digit_r;
    lit_nxt     = lit_r;
    elapsed_nxt = elapsed_r;
    dlatch_nxt  = dlatch_r;
    slatch_nxt  = slatch_r;
    if (cmd == CMD_TICK) begin
      elapsed_nxt = el_inc;
      case (phase_r)
        PH_SETUP: begin
          dlatch_nxt[digit_r] = 1'b1;
          slatch_nxt          = cur_pat;
          lit_nxt             = count_ones(cur_pat);
          phase_nxt           = PH_ON;
          elapsed_nxt         = '0;
        end
        PH_ON: begin
          if (el_inc > hold_time(lit_r)) begin
            dlatch_nxt  = '0;
            elapsed_nxt = '0;
            if (digit_r == DIGIT_W'(NUM_DIGITS - 1)) begin
              digit_nxt = '0;
              phase_nxt = PH_ALL_OFF;
            end else begin
              digit_nxt = digit_r + 1'b1;
              phase_nxt = PH_SETUP;
            end
          end
        end
        default: begin
          phase_nxt = (el_inc > ELAPSED_W'(cfg.off_time)) ? PH_SETUP : PH_ALL_OFF;
        end
      endcase
    end
  end

  always_comb begin
    dl4 = '0;
    for (int i = 0; i < DRIVE_W; i++) begin
      if (i < NUM_DIGITS) begin
        dl4[i] = dlatch_nxt[i];
      end
    end
  end

  assign result.digit_drive   = cfg.common_anode ? dl4 : ~dl4;
  assign result.segment_drive = cfg.common_anode ? ~slatch_nxt : slatch_nxt;
  assign result.phase_code    = phase_nxt;

endmodule

// ----- src/seven_segment_multiplexer.sv -----
// Top level: input beat register, multiplexer core, result register.
// Depends on sevseg_pkg, sevseg_if, sevseg_cfg and sevseg_core.
//
// Usage:
//   in_ch carries one beat per command: a one-microsecond tick (cmd 0) or a
//   pattern write for one digit (cmd 1). Every beat yields exactly one beat on
//   out_ch with the digit and segment pin levels and the phase after it.
//   cfg_we/cfg_index/cfg_wdata write common_anode (0), brightness_level (1)
//   and exponential_mode (2); write them only while no beat is in flight.
//   A beat passes the input register and then the result register before its
//   result is valid on out_ch. Throughput: one beat per cycle while out_ch
//   does not stall, set by the state update in the core.
//   When out_ch stalls the result register holds; the input register still
//   takes one more beat, after which in_ch.ready drops until out_ch drains.
//   Reset (rst_n low, synchronous) clears the pipeline, the phase machine,
//   the pattern store and the configuration registers; the first result then
//   shows all digits and segments off in the selected polarity.
module seven_segment_multiplexer (
  input  logic                             clk,
  input  logic                             rst_n,
  sevseg_in_if.sink                        in_ch,
  sevseg_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [sevseg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sevseg_pkg::LEVEL_W-1:0]   cfg_wdata
);
  import sevseg_pkg::*;

  logic             in_valid_r;
  logic             cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [SEG_W-1:0] pat_r;
  logic             out_valid_r;
  result_t          out_r;
  result_t          result;
  cfg_t             cfg;
  logic             advance;
  logic             step;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign step        = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      cmd_r <= in_ch.cmd;
      idx_r <= in_ch.digit_index;
      pat_r <= in_ch.segment_pattern;
    end
    if (step) begin
      out_r <= result;
    end
  end

  sevseg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sevseg_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .cmd             (cmd_r),
    .digit_index     (idx_r),
    .segment_pattern (pat_r),
    .cfg             (cfg),
    .result          (result)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.digit_drive   = out_r.digit_drive;
  assign out_ch.segment_drive = out_r.segment_drive;
  assign out_ch.phase_code    = out_r.phase_code;

endmodule
